@@ rtl/core/voxel_grid_point_dedup_defines.svh @@
// ----------------------------------------------------------------------------
// Voxel grid point dedup: assertion macros
// Shared concurrent assertion shorthands, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_POINT_DEDUP_DEFINES_SVH
`define VOXEL_GRID_POINT_DEDUP_DEFINES_SVH

// same-cycle implication
`define VGPD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VGPD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/vgpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Voxel grid point dedup: package
// Field widths, status codes, slot layout and the hash mixing step.
// ----------------------------------------------------------------------------
package vgpd_pkg;

   localparam int TABLE_DEPTH_DEF = 4096;
   localparam int PROBE_LIMIT_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int COORD_W  = 32;
   localparam int KEY_W    = 32;
   localparam int SCALE_W  = 32;
   localparam int USED_W   = 13;
   localparam int STATUS_W = 2;
   localparam int HASH_W   = 64;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd1310720;

   localparam logic [HASH_W-1:0] HASH_GOLDEN = 64'h0000_0000_9e37_79b9;
   localparam int HASH_LSHIFT = 6;
   localparam int HASH_RSHIFT = 2;

   localparam logic [STATUS_W-1:0] ST_DUP     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEW     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic signed [KEY_W-1:0] x;
      logic signed [KEY_W-1:0] y;
      logic signed [KEY_W-1:0] z;
   } key_type;

   typedef struct packed {
      logic    valid;
      key_type key;
   } slot_type;

   // h ^ (sext(k) + golden + (h << 6) + (h >> 2)), modulo 2^64
   function automatic logic [HASH_W-1:0] hash_mix(input logic [HASH_W-1:0] h,
                                                  input logic [KEY_W-1:0] k);
      logic [HASH_W-1:0] kw;
      kw = {{(HASH_W-KEY_W){k[KEY_W-1]}}, k};
      return h ^ (kw + HASH_GOLDEN + (h << HASH_LSHIFT) + (h >> HASH_RSHIFT));
   endfunction

endpackage

@@ rtl/core/voxel_grid_point_dedup.sv @@
// ----------------------------------------------------------------------------
// Voxel grid point dedup: top level
// Quantizes each point to a voxel, looks the voxel up in an open-addressing
// hash table with linear probing, inserts new voxels and drops duplicates.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  point_x/y/z, point_valid
//   rsp      out        rsp_valid/rsp_ready  keep_point, out_x/y/z, status, used
//   csr      in         csr_wr_en            voxel_scale
//
// For a valid point the shared quantizing multiplier runs three passes, the
// hash two mixing steps, then the single table read port checks one slot a
// cycle, for 1 to PROBE_LIMIT probes (at most TABLE_DEPTH). A depth that is
// not a power of two adds a serial hash reduction. An invalid point goes
// straight to the response. After reset a clearing pass writes every slot
// with req_ready low. A pending response does not block the next request.
// ----------------------------------------------------------------------------
`include "voxel_grid_point_dedup_defines.svh"

module voxel_grid_point_dedup #(
   parameter int TABLE_DEPTH = vgpd_pkg::TABLE_DEPTH_DEF,
   parameter int PROBE_LIMIT = vgpd_pkg::PROBE_LIMIT_DEF,
   parameter int FRAC_BITS   = vgpd_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [vgpd_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [vgpd_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [vgpd_pkg::COORD_W-1:0]  req_point_z,
   input  logic                                 req_point_valid,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_keep_point,
   output logic signed [vgpd_pkg::COORD_W-1:0]  rsp_out_x,
   output logic signed [vgpd_pkg::COORD_W-1:0]  rsp_out_y,
   output logic signed [vgpd_pkg::COORD_W-1:0]  rsp_out_z,
   output logic        [vgpd_pkg::STATUS_W-1:0] rsp_point_status,
   output logic        [vgpd_pkg::USED_W-1:0]   rsp_entries_used,

   input  logic                                 csr_wr_en,
   input  logic        [vgpd_pkg::SCALE_W-1:0]  csr_wr_data
);

   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int LIMIT_EFF = (PROBE_LIMIT < TABLE_DEPTH) ? PROBE_LIMIT : TABLE_DEPTH;
   localparam int PW        = $clog2(LIMIT_EFF + 1);
   localparam int CW        = ($clog2(TABLE_DEPTH + 1) > vgpd_pkg::USED_W) ?
                              $clog2(TABLE_DEPTH + 1) : vgpd_pkg::USED_W;
   localparam int SW        = $bits(vgpd_pkg::slot_type);
   localparam int CRW       = vgpd_pkg::COORD_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_QUANT = 3'd2;
   localparam logic [2:0] S_HASH  = 3'd3;
   localparam logic [2:0] S_PROBE = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic [AW-1:0]                  chk_ff, chk_in;
   logic [AW-1:0]                  next_slot;
   logic [PW-1:0]                  pcnt_ff, pcnt_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [vgpd_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                           qstart_ff, qstart_in;
   logic [vgpd_pkg::SCALE_W-1:0]   scale_ff;
   logic signed [CRW-1:0]          x_ff, y_ff, z_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           load_rsp;
   logic                           keep_ff;
   logic signed [CRW-1:0]          out_x_ff, out_y_ff, out_z_ff;
   logic [vgpd_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [vgpd_pkg::USED_W-1:0]    used_ff;

   logic                           ready_c;
   logic                           q_done;
   vgpd_pkg::key_type              q_keys;
   logic                           h_start;
   logic                           h_done;
   logic [AW-1:0]                  h_slot;

   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr;
   logic [SW-1:0]                  ram_wdata;
   logic [AW-1:0]                  ram_raddr;
   logic [SW-1:0]                  ram_rdata;
   vgpd_pkg::slot_type             rd_slot;
   vgpd_pkg::slot_type             new_slot;

   vgpd_quant #(
      .FRAC_BITS (FRAC_BITS)
   ) u_quant (
      .clock   (clock),
      .reset   (reset),
      .start   (qstart_ff),
      .coord_x (x_ff),
      .coord_y (y_ff),
      .coord_z (z_ff),
      .scale   (scale_ff),
      .done    (q_done),
      .keys    (q_keys)
   );

   vgpd_hash #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (h_start),
      .keys  (q_keys),
      .done  (h_done),
      .slot  (h_slot)
   );

   vgpd_ram #(
      .WIDTH (SW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_slot        = vgpd_pkg::slot_type'(ram_rdata);
   assign new_slot.valid = 1'b1;
   assign new_slot.key   = q_keys;
   assign next_slot      = (chk_ff == AW'(TABLE_DEPTH - 1)) ? '0 : chk_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      chk_in       = chk_ff;
      pcnt_in      = pcnt_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      qstart_in    = 1'b0;
      h_start      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = chk_ff;
      ram_wdata    = new_slot;
      ram_raddr    = next_slot;
      ready_c      = 1'b0;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ready_c = 1'b1;
            if (req_valid) begin
               if (req_point_valid) begin
                  qstart_in = 1'b1;
                  state_in  = S_QUANT;
               end else begin
                  status_in = vgpd_pkg::ST_INVALID;
                  state_in  = S_OUT;
               end
            end
         end
         S_QUANT: begin
            if (q_done) begin
               h_start  = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            // first probe read goes out as soon as the start slot is known
            ram_raddr = h_slot;
            if (h_done) begin
               chk_in   = h_slot;
               pcnt_in  = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            // data of chk_ff is here; the next slot is being read speculatively
            if (!rd_slot.valid) begin
               ram_we    = 1'b1;
               count_in  = count_ff + 1'b1;
               status_in = vgpd_pkg::ST_NEW;
               state_in  = S_OUT;
            end else if (rd_slot.key == q_keys) begin
               status_in = vgpd_pkg::ST_DUP;
               state_in  = S_OUT;
            end else if (pcnt_ff == PW'(LIMIT_EFF - 1)) begin
               status_in = vgpd_pkg::ST_FULL;
               state_in  = S_OUT;
            end else begin
               chk_in  = next_slot;
               pcnt_in = pcnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chk_ff       <= '0;
         pcnt_ff      <= '0;
         count_ff     <= '0;
         status_ff    <= vgpd_pkg::ST_DUP;
         qstart_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= vgpd_pkg::SCALE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_ff       <= chk_in;
         pcnt_ff      <= pcnt_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         qstart_ff    <= qstart_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && ready_c) begin
         x_ff <= req_point_x;
         y_ff <= req_point_y;
         z_ff <= req_point_z;
      end
      if (load_rsp) begin
         keep_ff       <= (status_ff == vgpd_pkg::ST_NEW);
         out_x_ff      <= x_ff;
         out_y_ff      <= y_ff;
         out_z_ff      <= z_ff;
         rsp_status_ff <= status_ff;
         used_ff       <= count_ff[vgpd_pkg::USED_W-1:0];
      end
   end

   assign req_ready        = ready_c;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_keep_point   = keep_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_out_z        = out_z_ff;
   assign rsp_point_status = rsp_status_ff;
   assign rsp_entries_used = used_ff;

   `VGPD_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request accepted while one in flight")
   `VGPD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(TABLE_DEPTH), "occupied count beyond table depth")
   `VGPD_ASSERT_NXT(a_count_on_insert, clock, reset, state_ff != S_PROBE, $stable(count_ff), "occupied count moved outside probing")
   `VGPD_ASSERT_IMP(a_probe_bound, clock, reset, state_ff == S_PROBE, pcnt_ff < PW'(LIMIT_EFF), "probe count past limit")

endmodule

@@ rtl/core/vgpd_ram.sv @@
// ----------------------------------------------------------------------------
// Voxel grid point dedup: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vgpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/vgpd_quant.sv @@
// ----------------------------------------------------------------------------
// Voxel grid point dedup: quantizer
// One shared multiplier turns x, y, z into voxel indices in turn:
// floor(coord * scale / 2^(2*FRAC_BITS)), saturated to 32 bits.
// ----------------------------------------------------------------------------
module vgpd_quant #(
   parameter int FRAC_BITS = vgpd_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [vgpd_pkg::COORD_W-1:0] coord_x,
   input  logic signed [vgpd_pkg::COORD_W-1:0] coord_y,
   input  logic signed [vgpd_pkg::COORD_W-1:0] coord_z,
   input  logic        [vgpd_pkg::SCALE_W-1:0] scale,
   output logic                                done,
   output vgpd_pkg::key_type                   keys
);

   localparam int PROD_W = vgpd_pkg::COORD_W + vgpd_pkg::SCALE_W + 1;
   localparam int SHIFT  = 2 * FRAC_BITS;
   localparam int KW     = vgpd_pkg::KEY_W;

   localparam logic signed [PROD_W-1:0] KEY_MAX = {{(PROD_W-KW+1){1'b0}}, {(KW-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] KEY_MIN = {{(PROD_W-KW+1){1'b1}}, {(KW-1){1'b0}}};

   logic [1:0]                          iss_ff;
   logic [2:0]                          sel_ff;
   logic                                done_ff;
   logic signed [vgpd_pkg::COORD_W-1:0] opnd;
   logic signed [PROD_W-1:0]            prod_in;
   logic signed [PROD_W-1:0]            prod_ff;
   logic signed [PROD_W-1:0]            quo;
   logic signed [KW-1:0]                sat;
   vgpd_pkg::key_type                   keys_ff;

   always_comb begin
      if (start) begin
         opnd = coord_x;
      end else if (iss_ff[0]) begin
         opnd = coord_y;
      end else begin
         opnd = coord_z;
      end
      prod_in = opnd * $signed({1'b0, scale});
   end

   // arithmetic shift of the product is the floor
   always_comb begin
      quo = prod_ff >>> SHIFT;
      if (quo > KEY_MAX) begin
         sat = KEY_MAX[KW-1:0];
      end else if (quo < KEY_MIN) begin
         sat = KEY_MIN[KW-1:0];
      end else begin
         sat = quo[KW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff  <= '0;
         sel_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         iss_ff  <= {iss_ff[0], start};
         sel_ff  <= {iss_ff[1], iss_ff[0], start};
         done_ff <= sel_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (sel_ff[0]) begin
         keys_ff.x <= sat;
      end
      if (sel_ff[1]) begin
         keys_ff.y <= sat;
      end
      if (sel_ff[2]) begin
         keys_ff.z <= sat;
      end
   end

   assign done = done_ff;
   assign keys = keys_ff;

endmodule

@@ rtl/core/vgpd_hash.sv @@
// ----------------------------------------------------------------------------
// Voxel grid point dedup: hash unit
// Two mixing steps over the voxel indices, then reduction to a start slot.
// A depth that is not a power of two takes a serial remainder, 8 bits a cycle.
// ----------------------------------------------------------------------------
module vgpd_hash #(
   parameter int TABLE_DEPTH = vgpd_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  vgpd_pkg::key_type              keys,
   output logic                           done,
   output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

   localparam int AW      = $clog2(TABLE_DEPTH);
   localparam int HW      = vgpd_pkg::HASH_W;
   localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

   logic          mix2_ff;
   logic          done_ff;
   logic [HW-1:0] h_ff;
   logic [HW-1:0] h_in;

   always_comb begin
      if (start) begin
         h_in = vgpd_pkg::hash_mix({{(HW-vgpd_pkg::KEY_W){keys.x[vgpd_pkg::KEY_W-1]}}, keys.x},
                                   keys.y);
      end else begin
         h_in = vgpd_pkg::hash_mix(h_ff, keys.z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix2_ff <= 1'b0;
      end else begin
         mix2_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start || mix2_ff) begin
         h_ff <= h_in;
      end
   end

   generate
      if (IS_POW2) begin : g_mask
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= mix2_ff;
            end
         end
         assign slot = h_ff[AW-1:0];
      end else begin : g_serial
         localparam int RW        = AW + 1;
         localparam int RED_BITS  = 8;
         localparam int RED_STEPS = HW / RED_BITS;
         localparam int CNT_W     = $clog2(RED_STEPS);

         logic [HW-1:0]    red_ff;
         logic [RW-1:0]    rem_ff;
         logic [RW-1:0]    rem_in;
         logic [CNT_W-1:0] chunk_ff;
         logic             busy_ff;

         // restoring remainder, MSB first, remainder stays below the depth
         always_comb begin
            rem_in = rem_ff;
            for (int j = 0; j < RED_BITS; j++) begin
               rem_in = {rem_in[RW-2:0], red_ff[HW-1-j]};
               if (rem_in >= RW'(TABLE_DEPTH)) begin
                  rem_in = rem_in - RW'(TABLE_DEPTH);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff  <= 1'b0;
               done_ff  <= 1'b0;
               chunk_ff <= '0;
            end else begin
               done_ff <= 1'b0;
               if (mix2_ff) begin
                  busy_ff  <= 1'b1;
                  chunk_ff <= '0;
               end else if (busy_ff) begin
                  chunk_ff <= chunk_ff + 1'b1;
                  if (chunk_ff == CNT_W'(RED_STEPS - 1)) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (mix2_ff) begin
               red_ff <= h_in;
               rem_ff <= '0;
            end else if (busy_ff) begin
               red_ff <= red_ff << RED_BITS;
               rem_ff <= rem_in;
            end
         end

         assign slot = rem_ff[AW-1:0];
      end
   endgenerate

   assign done = done_ff;

endmodule
